// ===== rtl/core/dmfa_pkg.sv =====
// shared types and constants for the decimal milli fixed-point alu
// no dependencies; imported by every module of the block
`default_nettype none

package dmfa_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MIN    = 3'd2,
    OP_MAX    = 3'd3,
    OP_MAKE   = 3'd4,
    OP_TRUNC  = 3'd5,
    OP_MUL    = 3'd6,
    OP_UNUSED = 3'd7
  } op_e;

  localparam int unsigned PartW   = 16;
  localparam int unsigned ScaledW = 26;   // holds 1000*whole + milli
  localparam int unsigned ProdW   = 32;
  localparam int unsigned FracW   = 10;   // a remainder of 1000 fits here

  localparam logic signed [PartW-1:0]   MilliMax  = 16'sd999;
  localparam logic signed [PartW-1:0]   MilliOne  = 16'sd1000;
  localparam logic signed [ScaledW-1:0] ScaleWide = 26'sd1000;
  localparam logic        [ScaledW-1:0] FixScale  = 26'd1000;

  // one input item
  typedef struct packed {
    logic [2:0]              op;
    logic signed [PartW-1:0] a_whole;
    logic signed [PartW-1:0] a_milli;
    logic signed [PartW-1:0] b_whole;
    logic signed [PartW-1:0] b_milli;
    logic signed [31:0]      fixed_word;
    logic                    fixed_sel;
  } dmfa_in_t;

  // one result item
  typedef struct packed {
    logic signed [PartW-1:0] r_whole;
    logic signed [PartW-1:0] r_milli;
  } dmfa_out_t;

  // front stage output: direct result or scaled operands for multiply
  typedef struct packed {
    logic                      is_mul;
    dmfa_out_t                 simple;
    logic signed [ScaledW-1:0] sa;
    logic signed [ScaledW-1:0] sb;
  } dmfa_front_t;

  // sideband that follows the multiply path
  typedef struct packed {
    logic      is_mul;
    logic      neg;
    dmfa_out_t simple;
  } dmfa_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/dmfa_front.sv =====
// first pipeline stage: decode, all operations other than multiply, operand scaling
// depends on dmfa_pkg
`default_nettype none

module dmfa_front (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire dmfa_pkg::dmfa_in_t in_i,
  output dmfa_pkg::dmfa_front_t   front_o
);
  import dmfa_pkg::*;

  logic signed [PartW-1:0] aw, am, bw, bm;
  logic signed [PartW-1:0] add_w, add_m, sub_w, sub_m;
  logic signed [PartW-1:0] add_w1, add_m1, sub_w1, sub_m1;
  logic                    a_greater;
  logic [ScaledW-1:0]      fix_prod;
  dmfa_out_t               simple;
  dmfa_front_t             front_d, front_q;

  assign aw = in_i.a_whole;
  assign am = in_i.a_milli;
  assign bw = in_i.b_whole;
  assign bm = in_i.b_milli;

  // add with one carry, subtract with one borrow
  assign add_m  = am + bm;
  assign add_w  = aw + bw;
  assign add_m1 = add_m - MilliOne;
  assign add_w1 = add_w + 16'sd1;
  assign sub_m  = am - bm;
  assign sub_w  = aw - bw;
  assign sub_m1 = sub_m + MilliOne;
  assign sub_w1 = sub_w - 16'sd1;

  assign a_greater = (aw > bw) || ((aw >= bw) && (am > bm));

  // fraction of a 16.16 word in thousandths
  assign fix_prod = FixScale * {10'd0, in_i.fixed_word[15:0]};

  // direct results
  always_comb begin
    simple = '0;
    if (in_i.fixed_sel) begin
      simple.r_whole = in_i.fixed_word[31:16];
      simple.r_milli = {6'd0, fix_prod[25:16]};
    end else begin
      unique case (op_e'(in_i.op)) inside
        OP_ADD: begin
          if (add_m > MilliMax) begin
            simple.r_whole = add_w1;
            simple.r_milli = add_m1;
          end else begin
            simple.r_whole = add_w;
            simple.r_milli = add_m;
          end
        end
        OP_SUB: begin
          if (sub_m < 16'sd0) begin
            simple.r_whole = sub_w1;
            simple.r_milli = sub_m1;
          end else begin
            simple.r_whole = sub_w;
            simple.r_milli = sub_m;
          end
          if (simple.r_whole < 16'sd0) begin
            simple.r_whole = '0;
            simple.r_milli = '0;
          end
        end
        OP_MIN: begin
          simple.r_whole = a_greater ? bw : aw;
          simple.r_milli = a_greater ? bm : am;
        end
        OP_MAX: begin
          simple.r_whole = a_greater ? aw : bw;
          simple.r_milli = a_greater ? am : bm;
        end
        OP_MAKE: begin
          simple.r_whole = aw;
          simple.r_milli = (bw > MilliMax) ? MilliMax : bw;
        end
        OP_TRUNC: begin
          simple.r_whole = aw;
          simple.r_milli = '0;
        end
        OP_MUL, OP_UNUSED: begin
          simple = '0;
        end
      endcase
    end
  end

  // scaled operands for the multiply path
  always_comb begin
    front_d.is_mul = !in_i.fixed_sel && (op_e'(in_i.op) == OP_MUL);
    front_d.simple = simple;
    front_d.sa     = ($signed({{10{aw[15]}}, aw}) * ScaleWide) + $signed({{10{am[15]}}, am});
    front_d.sb     = ($signed({{10{bw[15]}}, bw}) * ScaleWide) + $signed({{10{bm[15]}}, bm});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

`default_nettype wire

// ===== rtl/core/dmfa_mult.sv =====
// second pipeline stage: wrapping 32-bit product of the scaled operands
// depends on dmfa_pkg
`default_nettype none

module dmfa_mult (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire logic signed [dmfa_pkg::ScaledW-1:0]   sa_i,
  input  wire logic signed [dmfa_pkg::ScaledW-1:0]   sb_i,
  output logic signed [dmfa_pkg::ProdW-1:0]          prod_o
);
  import dmfa_pkg::*;

  logic signed [ProdW-1:0] ea, eb, prod_d, prod_q;

  // sign-extend and keep the low product bits
  assign ea     = ProdW'(sa_i);
  assign eb     = ProdW'(sb_i);
  assign prod_d = ea * eb;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== rtl/core/dmfa_div1k.sv =====
// two-stage unsigned divide by 1000: reciprocal multiply, then one correction
// depends on dmfa_pkg
`default_nettype none

module dmfa_div1k #(
  parameter int unsigned W = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [W-1:0]                  n_i,
  output logic [W-10:0]                      q_o,
  output logic [dmfa_pkg::FracW-1:0]         r_o
);
  import dmfa_pkg::*;

  localparam int unsigned   QW    = W - 9;
  localparam logic [W-1:0]  Recip = W'((64'd1 << W) / 64'd1000);
  localparam logic [W-1:0]  Div   = W'(1000);

  logic [2*W-1:0] est;
  logic [QW-1:0]  q0_d, q0_q, q_d, q_q;
  logic [W-1:0]   n_q, rem;
  logic [FracW-1:0] r_d, r_q;

  // estimate is the true quotient or one below it
  assign est  = {{W{1'b0}}, n_i} * {{W{1'b0}}, Recip};
  assign q0_d = est[W +: QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q  <= n_i;
      q0_q <= q0_d;
    end
  end

  // remainder and single correction step
  assign rem = n_q - ({{(W-QW){1'b0}}, q0_q} * Div);

  always_comb begin
    if (rem >= Div) begin
      q_d = q0_q + QW'(1);
      r_d = FracW'(rem - Div);
    end else begin
      q_d = q0_q;
      r_d = FracW'(rem);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/decimal_milli_fixed_alu.sv =====
// decimal milli fixed-point alu, top level: seven-stage pipeline
// depends on dmfa_pkg, dmfa_front, dmfa_mult, dmfa_div1k
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one item per
//   transfer: opcode, two (whole, thousandths) operands and a 16.16 word.
//   Output channel out_valid_o / out_stall_i / out_data_o returns exactly
//   one result per item, in order.
//   Throughput is one item per cycle while the receiver is not stalling.
//   Every operation runs through the same seven stages: front decode and
//   scaling, the 26x26 product, then two divide-by-1000 units of two
//   stages each, then sign and result select.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_stall_o is raised, so nothing is dropped or repeated;
//   bubbles travel as cleared valid bits.
//   Reset clears all valid bits; no result is presented until new items
//   arrive. There is no configuration and no state between items.
`default_nettype none

module decimal_milli_fixed_alu (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire dmfa_pkg::dmfa_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output dmfa_pkg::dmfa_out_t      out_data_o
);
  import dmfa_pkg::*;

  localparam int unsigned Depth = 7;

  logic                     en;
  logic [Depth:1]           valid_q;
  dmfa_front_t              front;
  logic signed [ProdW-1:0]  prod;
  logic [ProdW-1:0]         mag;
  logic [ProdW-10:0]        q1;
  logic [FracW-1:0]         r1;
  logic [12:0]              q2;
  logic [FracW-1:0]         r2;
  dmfa_side_t               side_q [2:6];
  dmfa_side_t               side3_d;
  dmfa_out_t                out_d, out_q;
  logic [PartW-1:0]         mw, mm;

  // the pipeline advances unless a result waits on a stalled receiver
  assign en         = !(valid_q[Depth] && out_stall_i);
  assign in_stall_o = !en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Depth-1:1], in_valid_i};
    end
  end

  dmfa_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .in_i    (in_data_i),
    .front_o (front)
  );

  dmfa_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (en),
    .sa_i   (front.sa),
    .sb_i   (front.sb),
    .prod_o (prod)
  );

  // magnitude of the product; the sign is carried alongside
  assign mag = prod[ProdW-1] ? (~prod + ProdW'(1)) : prod;

  dmfa_div1k #(.W(ProdW)) u_div_prod (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (mag),
    .q_o   (q1),
    .r_o   (r1)
  );

  dmfa_div1k #(.W(22)) u_div_quot (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (q1[21:0]),
    .q_o   (q2),
    .r_o   (r2)
  );

  // sideband alongside the multiply path
  always_comb begin
    side3_d     = side_q[2];
    side3_d.neg = prod[ProdW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[2] <= '{is_mul: front.is_mul, neg: 1'b0, simple: front.simple};
      side_q[3] <= side3_d;
      side_q[4] <= side_q[3];
      side_q[5] <= side_q[4];
      side_q[6] <= side_q[5];
    end
  end

  // signed multiply result and final select
  assign mw = {3'd0, q2};
  assign mm = {6'd0, r2};

  always_comb begin
    if (side_q[6].is_mul) begin
      out_d.r_whole = side_q[6].neg ? -mw : mw;
      out_d.r_milli = side_q[6].neg ? -mm : mm;
    end else begin
      out_d = side_q[6].simple;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[Depth];
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
